// ----- hw/rtl/lfu_pkg.sv -----
// shared types and constants for the lfu cache replacement block
`timescale 1ns / 1ps
`default_nettype none

package lfu_pkg;

  localparam int ADDR_W     = 31;  // block address and tag width
  localparam int CAP_W      = 7;   // capacity register width
  localparam int OUT_W      = 32;  // reported counter width
  localparam int SLOT_OUT_W = 6;   // reported slot index width
  localparam int S_DATA_W   = 32;  // input tdata width
  localparam int M_DATA_W   = 136; // result tdata width
  localparam int APB_AW     = 3;   // paddr width
  localparam int APB_DW     = 32;  // pwdata / prdata width

  // register indexes
  localparam logic [0:0] REG_CAPACITY = 1'b0;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // controller to datapath
  typedef struct packed {
    logic load;    // take the input transaction, bump counters
    logic issue;   // read the slot at the scan pointer
    logic commit;  // write the chosen slot, update fill and miss counts
    logic emit;    // load the result register
  } lfu_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;       // no slot filled yet
    logic issue_last;  // scan pointer is at the last filled slot
    logic out_free;    // result register can take a new result
  } lfu_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lfu_cache_replacement.sv -----
// top level of the lfu cache replacement block: config register and core
//
// channel  | dir | handshake              | contents
// s_*      | in  | s_tvalid / s_tready    | address of one access
// m_*      | out | m_tvalid / m_tready    | hit, slot, eviction, running totals
// apb      | in  | psel, penable, pwrite  | capacity register at byte address 0
//
// each access scans every filled slot at one slot ram read per cycle, then drains, commits
// and emits before the next ready; while no slot is filled it goes straight to commit
// a result waiting in the output register holds only the last step of the next access
// reset is synchronous, clears counters and fill count; no ram clearing pass
// capacity must be written while the block is idle; the block itself does not enforce this
`timescale 1ns / 1ps
`default_nettype none

module lfu_cache_replacement
  import lfu_pkg::*;
#(
  parameter int SLOTS      = 64,
  parameter int COUNT_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // input stream
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,  // [30:0] address, [31] unused
  // result stream
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // [0] hit, [6:1] slot_index, [7] evicted, [38:8] evicted_address,
  // [70:39] access_total, [102:71] miss_total, [134:103] fill_mark, [135] zero
  output logic      [M_DATA_W-1:0] m_tdata,
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [APB_AW-1:0]   paddr,
  input  wire logic [APB_DW-1:0]   pwdata,
  output logic      [APB_DW-1:0]   prdata,
  output logic                     pready
);

  logic [CAP_W-1:0] capacity;
  lfu_cmd_t         cmd;
  lfu_status_t      status;

  assign pready = 1'b1;

  // register index is paddr[2]; only the capacity register exists
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY)) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DW'(capacity) : '0;

  // controller: accept, scan, drain, commit, emit
  lfu_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  // datapath: slot ram, match and victim search, counters, result register
  lfu_dp #(
    .SLOTS     (SLOTS),
    .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .capacity(capacity),
    .address (s_tdata[ADDR_W-1:0]),
    .cmd     (cmd),
    .status  (status),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/lfu_ram.sv -----
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lfu_ctrl.sv -----
// sequencing state machine for the lfu cache replacement block
`timescale 1ns / 1ps
`default_nettype none

module lfu_ctrl
  import lfu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire lfu_status_t status,
  output lfu_cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_EMIT
  } state_t;

  state_t state;

  always_comb begin
    cmd.load   = (state == ST_IDLE) && s_tvalid && s_tready;
    cmd.issue  = (state == ST_SCAN);
    cmd.commit = (state == ST_COMMIT);
    cmd.emit   = (state == ST_EMIT) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      s_tready <= 1'b1;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            s_tready <= 1'b0;
            state    <= status.empty ? ST_COMMIT : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (status.issue_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_COMMIT;
        end
        ST_COMMIT: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (status.out_free) begin
            state    <= ST_IDLE;
            s_tready <= 1'b1;
          end
        end
        default: begin
          state    <= ST_IDLE;
          s_tready <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lfu_dp.sv -----
// datapath: slot ram, tag match, victim search, counters, result register
`timescale 1ns / 1ps
`default_nettype none

module lfu_dp
  import lfu_pkg::*;
#(
  parameter int SLOTS      = 64,
  parameter int COUNT_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [CAP_W-1:0]    capacity,
  input  wire logic [ADDR_W-1:0]   address,
  input  wire lfu_cmd_t            cmd,
  output lfu_status_t              status,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic      [M_DATA_W-1:0] m_tdata
);

  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FILL_W = $clog2(SLOTS + 1);
  localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;
  localparam int WORD_W = ADDR_W + 2 * COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // per-item registers
  logic [ADDR_W-1:0]     addr_q;
  logic                  full_q;
  logic [FILL_W-1:0]     rd_cnt;
  logic                  cmp_valid;
  logic [IDX_W-1:0]      cmp_idx;
  logic                  hit_q;
  logic [IDX_W-1:0]      hit_idx;
  logic [COUNT_BITS-1:0] hit_cnt;
  logic [IDX_W-1:0]      best_idx;
  logic [COUNT_BITS-1:0] best_cnt;
  logic [COUNT_BITS-1:0] best_stamp;
  logic [ADDR_W-1:0]     best_tag;
  logic [IDX_W-1:0]      slot_q;
  logic                  ev_q;
  logic [ADDR_W-1:0]     ev_addr_q;

  // block state
  logic [FILL_W-1:0]     filled;
  logic [COUNT_BITS-1:0] access_cnt;
  logic [COUNT_BITS-1:0] miss_cnt;
  logic [COUNT_BITS-1:0] fill_cnt;

  // slot ram
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [WORD_W-1:0]     ram_wdata;
  logic [WORD_W-1:0]     ram_rdata;
  logic [ADDR_W-1:0]     rd_tag;
  logic [COUNT_BITS-1:0] rd_use;
  logic [COUNT_BITS-1:0] rd_stamp;

  logic [CMP_W-1:0]      cap_eff;
  logic [COUNT_BITS-1:0] access_inc;
  logic [COUNT_BITS-1:0] wr_use;
  logic                  take_victim;
  logic [OUT_W-1:0]      access_out;
  logic [OUT_W-1:0]      miss_out;
  logic [OUT_W-1:0]      fill_out;

  lfu_ram #(
    .WIDTH(WORD_W),
    .DEPTH(SLOTS),
    .AW   (IDX_W)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_cnt[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  assign rd_tag   = ram_rdata[WORD_W-1 -: ADDR_W];
  assign rd_use   = ram_rdata[2*COUNT_BITS-1 -: COUNT_BITS];
  assign rd_stamp = ram_rdata[COUNT_BITS-1:0];

  // capacity 0 acts as 1, above the slot count acts as the slot count
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(SLOTS)) begin
      cap_eff = CMP_W'(SLOTS);
    end else begin
      cap_eff = CMP_W'(capacity);
    end
  end

  assign access_inc = (access_cnt == CNT_MAX) ? access_cnt : access_cnt + 1'b1;

  assign status.empty      = (filled == '0);
  assign status.issue_last = ((rd_cnt + FILL_W'(1)) == filled);
  assign status.out_free   = !m_tvalid || m_tready;

  // lowest count wins, then oldest stamp, then lowest index
  assign take_victim = (cmp_idx == '0) || (rd_use < best_cnt) ||
                       ((rd_use == best_cnt) && (rd_stamp < best_stamp));

  // slot write on commit
  always_comb begin
    ram_we = cmd.commit;
    wr_use = COUNT_BITS'(1);
    if (hit_q) begin
      ram_waddr = hit_idx;
      wr_use    = (hit_cnt == CNT_MAX) ? hit_cnt : hit_cnt + 1'b1;
    end else if (!full_q) begin
      ram_waddr = filled[IDX_W-1:0];
    end else begin
      ram_waddr = best_idx;
    end
    ram_wdata = {addr_q, wr_use, access_cnt};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_q <= address;
      full_q <= (CMP_W'(filled) >= cap_eff);
      hit_q  <= 1'b0;
    end
    if (cmp_valid) begin
      if (!hit_q && (rd_tag == addr_q)) begin
        hit_q   <= 1'b1;
        hit_idx <= cmp_idx;
        hit_cnt <= rd_use;
      end
      if (take_victim) begin
        best_idx   <= cmp_idx;
        best_cnt   <= rd_use;
        best_stamp <= rd_stamp;
        best_tag   <= rd_tag;
      end
    end
    if (cmd.load) begin
      rd_cnt <= '0;
    end else if (cmd.issue) begin
      rd_cnt <= rd_cnt + FILL_W'(1);
    end
    cmp_idx <= rd_cnt[IDX_W-1:0];
    if (cmd.commit) begin
      slot_q    <= ram_waddr;
      ev_q      <= !hit_q && full_q;
      ev_addr_q <= (!hit_q && full_q) ? best_tag : '0;
    end
    if (cmd.emit) begin
      m_tdata <= {1'b0, fill_out, miss_out, access_out, ev_addr_q, ev_q,
                  SLOT_OUT_W'(slot_q), hit_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid  <= 1'b0;
      filled     <= '0;
      access_cnt <= '0;
      miss_cnt   <= '0;
      fill_cnt   <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      cmp_valid <= cmd.issue;
      if (cmd.load) begin
        access_cnt <= access_inc;
        if (CMP_W'(filled) < cap_eff) begin
          fill_cnt <= access_inc;
        end
      end
      if (cmd.commit && !hit_q) begin
        miss_cnt <= (miss_cnt == CNT_MAX) ? miss_cnt : miss_cnt + 1'b1;
        if (!full_q) begin
          filled <= filled + FILL_W'(1);
        end
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // reported totals clip at all ones when the counters are wider than the output, else zero extend
  generate
    if (COUNT_BITS > OUT_W) begin : g_clip
      assign access_out = (|access_cnt[COUNT_BITS-1:OUT_W]) ? '1 : access_cnt[OUT_W-1:0];
      assign miss_out   = (|miss_cnt[COUNT_BITS-1:OUT_W]) ? '1 : miss_cnt[OUT_W-1:0];
      assign fill_out   = (|fill_cnt[COUNT_BITS-1:OUT_W]) ? '1 : fill_cnt[OUT_W-1:0];
    end else begin : g_ext
      assign access_out = OUT_W'(access_cnt);
      assign miss_out   = OUT_W'(miss_cnt);
      assign fill_out   = OUT_W'(fill_cnt);
    end
  endgenerate

endmodule

`default_nettype wire

// ----- hw/rtl/lfu_checker.sv -----
// port-level checks for the lfu cache replacement block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module lfu_checker
  import lfu_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                s_tvalid,
  input wire logic                s_tready,
  input wire logic                m_tvalid,
  input wire logic                m_tready,
  input wire logic [M_DATA_W-1:0] m_tdata
);

  // no result survives reset
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // one access at a time: ready drops after a transaction
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second access taken while busy");

  // eviction only on a miss, and the evicted address is zero otherwise
  a_evict_consistent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7] ? !m_tdata[0] : (m_tdata[38:8] == '0)))
    else $error("eviction fields inconsistent");

  // misses never outnumber accesses
  a_miss_le_access: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[102:71] <= m_tdata[70:39]))
    else $error("miss total above access total");

endmodule

bind lfu_cache_replacement lfu_checker u_lfu_checker (.*);

`default_nettype wire
